>>> src/dote_pkg.sv
// Shared types and constants for the DHCP option time extractor.
`default_nettype none
package dote_pkg;

  // Option codes of interest.
  localparam logic [7:0] OptEnd       = 8'hFF;
  localparam logic [7:0] OptPad       = 8'h00;
  localparam logic [7:0] OptLease     = 8'd51;
  localparam logic [7:0] OptRenewal   = 8'd58;
  localparam logic [7:0] OptRebinding = 8'd59;

  localparam int unsigned CookieBytes = 4;

  // Stop reason codes.
  localparam logic [1:0] StopEnd       = 2'd0;
  localparam logic [1:0] StopPad       = 2'd1;
  localparam logic [1:0] StopExhausted = 2'd2;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic       packet_start;
    logic       packet_end;
  } in_req_t;

  typedef struct packed {
    logic [31:0] lease_seconds;
    logic [31:0] renewal_seconds;
    logic [31:0] rebinding_seconds;
    logic [1:0]  stop_reason;
  } out_res_t;

endpackage
`default_nettype wire

>>> src/dhcp_option_time_extractor_core.sv
// Top level of the DHCP option time extractor.
`default_nettype none
// Walks a DHCP options area one byte per request: the four cookie bytes are
// passed over, then type-length-value options are followed. A type byte of
// 0xFF or 0x00 stops the parse; so does a byte flagged packet_end or byte
// AREA_BYTES-1 of the area. For options 51, 58 and 59 the four bytes after the
// length byte are captured big-endian into the lease, renewal and rebinding
// values, which persist across packets and reset to zero. Exactly one result
// leaves when a parse stops, carrying all three values and the stop reason
// (0 end marker, 1 pad byte, 2 area exhausted). packet_start always restarts
// the parse; bytes outside a parse are consumed silently.
// Rate: one request per cycle sustained. A request is held in the input
// register until the parse step takes it; that step updates state and loads the
// result register, so out_valid rises on the edge at which the parse step
// takes the final byte. The only stall is a result waiting in the result
// register, which holds the byte in the input register until out_ready.
module dhcp_option_time_extractor_core #(
  parameter int unsigned AREA_BYTES = 312
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dote_pkg::in_req_t in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dote_pkg::out_res_t     out_res
);

  // Registered request handed to the parse step.
  logic              s_valid;
  logic              s_take;
  dote_pkg::in_req_t s_req;

  dote_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .s_valid  (s_valid),
    .s_req    (s_req),
    .s_take   (s_take)
  );

  // Parse state, value capture and result register.
  dote_parser #(
    .AREA_BYTES (AREA_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .s_req     (s_req),
    .s_take    (s_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

>>> src/dote_in_reg.sv
// Input register stage for option byte requests.
`default_nettype none
module dote_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dote_pkg::in_req_t in_req,
  output logic                   s_valid,
  output dote_pkg::in_req_t      s_req,
  input  wire logic              s_take
);

  logic              valid_r;
  dote_pkg::in_req_t req_r;

  assign in_ready = !valid_r || s_take;
  assign s_valid  = valid_r;
  assign s_req    = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

endmodule
`default_nettype wire

>>> src/dote_parser.sv
// Option walker: parse state, time value capture and the result register.
`default_nettype none
module dote_parser #(
  parameter int unsigned AREA_BYTES = 312
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s_valid,
  input  wire dote_pkg::in_req_t s_req,
  output logic                   s_take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dote_pkg::out_res_t     out_res
);

  localparam int unsigned PosW = $clog2(AREA_BYTES);
  localparam logic [PosW-1:0] PosCookieLast = PosW'(dote_pkg::CookieBytes - 1);
  localparam logic [PosW-1:0] PosAreaLast   = PosW'(AREA_BYTES - 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_COOKIE, PH_TYPE, PH_LENGTH, PH_SKIP, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    TGT_NONE, TGT_LEASE, TGT_RENEWAL, TGT_REBINDING
  } target_t;

  phase_t             phase_r, phase_nxt;
  logic [PosW-1:0]    pos_r, pos_nxt;
  logic [7:0]         skip_r, skip_nxt;
  logic [2:0]         cap_rem_r, cap_rem_nxt;
  target_t            tgt_r, tgt_nxt;
  logic [31:0]        shf_r, shf_nxt;
  logic [31:0]        lease_r, lease_nxt;
  logic [31:0]        renew_r, renew_nxt;
  logic [31:0]        rebind_r, rebind_nxt;
  logic               out_valid_r;
  dote_pkg::out_res_t out_res_r;

  logic       emit;
  logic [1:0] reason;
  logic       do_collect;
  logic       do_arm;
  logic [7:0] b;

  assign b         = s_req.opt_byte;
  assign s_take    = s_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    skip_nxt    = skip_r;
    cap_rem_nxt = cap_rem_r;
    tgt_nxt     = tgt_r;
    shf_nxt     = shf_r;
    lease_nxt   = lease_r;
    renew_nxt   = renew_r;
    rebind_nxt  = rebind_r;
    emit        = 1'b0;
    reason      = dote_pkg::StopExhausted;
    do_collect  = 1'b0;
    do_arm      = 1'b0;

    if (s_req.packet_start) begin
      phase_nxt   = PH_COOKIE;
      pos_nxt     = '0;
      skip_nxt    = '0;
      cap_rem_nxt = '0;
      tgt_nxt     = TGT_NONE;
      shf_nxt     = '0;
    end

    if (phase_nxt != PH_IDLE && phase_nxt != PH_DONE) begin
      unique case (phase_nxt)
        PH_COOKIE: begin
          if (pos_nxt >= PosCookieLast) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (b == dote_pkg::OptEnd) begin
            emit   = 1'b1;
            reason = dote_pkg::StopEnd;
          end else if (b == dote_pkg::OptPad) begin
            emit   = 1'b1;
            reason = dote_pkg::StopPad;
          end else begin
            if (b == dote_pkg::OptLease || b == dote_pkg::OptRenewal ||
                b == dote_pkg::OptRebinding) begin
              // New time option: drop any open capture and arm for this one.
              cap_rem_nxt = '0;
              shf_nxt     = '0;
              tgt_nxt     = (b == dote_pkg::OptLease)   ? TGT_LEASE :
                            (b == dote_pkg::OptRenewal) ? TGT_RENEWAL : TGT_REBINDING;
            end else begin
              do_collect = 1'b1;
            end
            phase_nxt = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          do_collect = 1'b1;
          do_arm     = 1'b1;
          if (b == 8'd0) begin
            phase_nxt = PH_TYPE;
          end else begin
            skip_nxt  = b;
            phase_nxt = PH_SKIP;
          end
        end
        default: begin // PH_SKIP
          do_collect = 1'b1;
          if (skip_nxt != 8'd0) begin
            skip_nxt = skip_nxt - 8'd1;
          end
          if (skip_nxt == 8'd0) begin
            phase_nxt = PH_TYPE;
          end
        end
      endcase

      // Shift one byte into the open capture; commit on the fourth.
      if (do_collect && tgt_nxt != TGT_NONE && cap_rem_nxt != 3'd0) begin
        shf_nxt     = {shf_nxt[23:0], b};
        cap_rem_nxt = cap_rem_nxt - 3'd1;
        if (cap_rem_nxt == 3'd0) begin
          case (tgt_nxt)
            TGT_LEASE:   lease_nxt  = shf_nxt;
            TGT_RENEWAL: renew_nxt  = shf_nxt;
            default:     rebind_nxt = shf_nxt;
          endcase
          tgt_nxt = TGT_NONE;
          shf_nxt = '0;
        end
      end

      if (do_arm && tgt_nxt != TGT_NONE && cap_rem_nxt == 3'd0) begin
        cap_rem_nxt = 3'd4;
      end

      if (!emit) begin
        if (s_req.packet_end || pos_nxt >= PosAreaLast) begin
          emit   = 1'b1;
          reason = dote_pkg::StopExhausted;
        end else begin
          pos_nxt = pos_nxt + PosW'(1);
        end
      end

      if (emit) begin
        phase_nxt   = PH_DONE;
        cap_rem_nxt = '0;
        tgt_nxt     = TGT_NONE;
        shf_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      skip_r      <= '0;
      cap_rem_r   <= '0;
      tgt_r       <= TGT_NONE;
      shf_r       <= '0;
      lease_r     <= '0;
      renew_r     <= '0;
      rebind_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s_take) begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        skip_r    <= skip_nxt;
        cap_rem_r <= cap_rem_nxt;
        tgt_r     <= tgt_nxt;
        shf_r     <= shf_nxt;
        lease_r   <= lease_nxt;
        renew_r   <= renew_nxt;
        rebind_r  <= rebind_nxt;
        if (emit) begin
          out_valid_r                 <= 1'b1;
          out_res_r.lease_seconds     <= lease_nxt;
          out_res_r.renewal_seconds   <= renew_nxt;
          out_res_r.rebinding_seconds <= rebind_nxt;
          out_res_r.stop_reason       <= reason;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> test/dote_checker.sv
`timescale 1ns / 1ps
// Checker for the DHCP option time extractor: tracks requests, predicts and compares results.
module dote_checker #(
  parameter int unsigned AREA_BYTES = 312
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  dote_pkg::in_req_t  in_req,
  input  logic               out_valid,
  input  logic               out_ready,
  input  dote_pkg::out_res_t out_res,
  output int                 n_errors,
  output int                 n_pending
);

  typedef enum logic [2:0] {
    PhIdle, PhCookie, PhType, PhLength, PhSkip, PhDone
  } walk_phase_t;

  typedef enum logic [1:0] {
    TgtNone, TgtLease, TgtRenewal, TgtRebinding
  } time_target_t;

  walk_phase_t  phase;
  logic [8:0]   pos;
  logic [7:0]   skip_left;
  logic [2:0]   cap_left;
  time_target_t cap_tgt;
  logic [31:0]  cap_shift;
  logic [31:0]  lease_s;
  logic [31:0]  renew_s;
  logic [31:0]  rebind_s;

  dote_pkg::out_res_t time_reports[$];
  int                 err_cnt = 0;

  task automatic clear_capture();
    cap_left  = '0;
    cap_tgt   = TgtNone;
    cap_shift = '0;
  endtask

  // Shift one byte into an open capture; commit on the fourth.
  task automatic collect_byte(input logic [7:0] b);
    if (cap_tgt != TgtNone && cap_left != 3'd0) begin
      cap_shift = {cap_shift[23:0], b};
      cap_left  = cap_left - 3'd1;
      if (cap_left == 3'd0) begin
        case (cap_tgt)
          TgtLease:   lease_s = cap_shift;
          TgtRenewal: renew_s = cap_shift;
          default:    rebind_s = cap_shift;
        endcase
        clear_capture();
      end
    end
  endtask

  task automatic report_stop(input logic [1:0] why);
    dote_pkg::out_res_t r;
    r.lease_seconds     = lease_s;
    r.renewal_seconds   = renew_s;
    r.rebinding_seconds = rebind_s;
    r.stop_reason       = why;
    time_reports.push_back(r);
    phase = PhDone;
    clear_capture();
  endtask

  task automatic walk_byte(input dote_pkg::in_req_t r);
    logic [7:0] b;
    b = r.opt_byte;
    if (r.packet_start) begin
      phase     = PhCookie;
      pos       = '0;
      skip_left = '0;
      clear_capture();
    end
    if (phase == PhIdle || phase == PhDone) return;

    case (phase)
      PhCookie: begin
        if (int'(pos) + 1 >= int'(dote_pkg::CookieBytes)) phase = PhType;
      end
      PhType: begin
        if (b == dote_pkg::OptEnd) begin
          report_stop(dote_pkg::StopEnd);
          return;
        end
        if (b == dote_pkg::OptPad) begin
          report_stop(dote_pkg::StopPad);
          return;
        end
        if (b == dote_pkg::OptLease || b == dote_pkg::OptRenewal ||
            b == dote_pkg::OptRebinding) begin
          clear_capture();
          if (b == dote_pkg::OptLease) cap_tgt = TgtLease;
          else if (b == dote_pkg::OptRenewal) cap_tgt = TgtRenewal;
          else cap_tgt = TgtRebinding;
        end else begin
          collect_byte(b);
        end
        phase = PhLength;
      end
      PhLength: begin
        collect_byte(b);
        // capture window opens on the byte after the length
        if (cap_tgt != TgtNone && cap_left == 3'd0) cap_left = 3'd4;
        if (b == 8'd0) begin
          phase = PhType;
        end else begin
          skip_left = b;
          phase     = PhSkip;
        end
      end
      default: begin
        collect_byte(b);
        if (skip_left != 8'd0) skip_left = skip_left - 8'd1;
        if (skip_left == 8'd0) phase = PhType;
      end
    endcase

    if (r.packet_end || int'(pos) + 1 >= int'(AREA_BYTES)) begin
      report_stop(dote_pkg::StopExhausted);
      return;
    end
    pos = pos + 9'd1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    dote_pkg::out_res_t want;
    if (!rst_n) begin
      phase     = PhIdle;
      pos       = '0;
      skip_left = '0;
      clear_capture();
      lease_s   = '0;
      renew_s   = '0;
      rebind_s  = '0;
      time_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (time_reports.size() == 0) begin
          $error("stop_reason: expected no result, got %0d", out_res.stop_reason);
          err_cnt++;
        end else begin
          want = time_reports.pop_front();
          check_field("lease_seconds", want.lease_seconds, out_res.lease_seconds);
          check_field("renewal_seconds", want.renewal_seconds, out_res.renewal_seconds);
          check_field("rebinding_seconds", want.rebinding_seconds,
                      out_res.rebinding_seconds);
          check_field("stop_reason", 32'(want.stop_reason), 32'(out_res.stop_reason));
        end
      end
      if (in_valid && in_ready) walk_byte(in_req);
    end
    n_errors  <= err_cnt;
    n_pending <= time_reports.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench top: feeds DHCP option areas to the time extractor and reports the verdict.
module tb;

  localparam int unsigned AreaBytes  = 312;
  localparam int          CycleLimit = 400000;
  localparam int          HoldCycles = 400;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  dote_pkg::in_req_t  in_req;
  logic               out_valid;
  logic               out_ready;
  dote_pkg::out_res_t out_res;

  int   n_errors;
  int   n_pending;
  int   cycles = 0;
  int   src_idle_pct = 0;    // chance per request of a gap before it
  int   sink_stall_pct = 0;  // chance per cycle that out_ready is low
  logic long_hold = 1'b0;    // asks the receiver for one long hold-off

  dote_pkg::in_req_t pkt[$]; // bytes of the options area being built

  always #10 clk = ~clk;

  dhcp_option_time_extractor_core #(
    .AREA_BYTES (AreaBytes)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  dote_checker #(
    .AREA_BYTES (AreaBytes)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .n_errors  (n_errors),
    .n_pending (n_pending)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Receiver. Random stalls at the current rate; on request it holds out_ready
  // low for one long hold-off so results back up and the block stalls its input.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        long_hold <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic dote_pkg::in_req_t opt_req(input logic [7:0] b, input logic s,
                                                input logic e);
    dote_pkg::in_req_t r;
    r.opt_byte     = b;
    r.packet_start = s;
    r.packet_end   = e;
    return r;
  endfunction

  // Byte values with the stop codes 0x00 and 0xFF made common.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return dote_pkg::OptPad;
      1:       return dote_pkg::OptEnd;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One request: optional idle gap, then hold valid until accepted. Valid
  // is only lowered on a gap cycle so it never toggles within one step.
  task automatic send_req(input dote_pkg::in_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_pkt();
    foreach (pkt[i]) send_req(pkt[i]);
  endtask

  // Stop offering and wait until every predicted result has been taken.
  // n_pending is registered in the checker, hence the first wait.
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic mark_last();
    dote_pkg::in_req_t r;
    r = pkt.pop_back();
    r.packet_end = 1'b1;
    pkt.push_back(r);
  endtask

  // Well-formed area: cookie, a few options (time options favored, length
  // mostly 4), then an end marker, a pad byte, nothing, or a cut-off tail.
  task automatic build_good();
    int                n_opt;
    int                len;
    int                k;
    int                idx;
    logic [7:0]        code;
    dote_pkg::in_req_t r;
    pkt.delete();
    pkt.push_back(opt_req(rand_byte(), 1'b1, 1'b0));
    repeat (3) pkt.push_back(opt_req(rand_byte(), 1'b0, 1'b0));
    n_opt = $urandom_range(0, 4);
    repeat (n_opt) begin
      case ($urandom_range(0, 9))
        0, 1:    code = dote_pkg::OptLease;
        2, 3:    code = dote_pkg::OptRenewal;
        4, 5:    code = dote_pkg::OptRebinding;
        default: code = 8'($urandom_range(1, 254));
      endcase
      k = $urandom_range(0, 9);
      if (k < 7) len = 4;
      else if (k < 9) len = $urandom_range(0, 8);
      else len = $urandom_range(9, 40);
      pkt.push_back(opt_req(code, 1'b0, 1'b0));
      pkt.push_back(opt_req(8'(len), 1'b0, 1'b0));
      repeat (len) pkt.push_back(opt_req(rand_byte(), 1'b0, 1'b0));
    end
    k = $urandom_range(0, 9);
    if (k < 6) begin
      pkt.push_back(opt_req(dote_pkg::OptEnd, 1'b0, 1'b0));
    end else if (k < 8) begin
      pkt.push_back(opt_req(dote_pkg::OptPad, 1'b0, 1'b0));
    end else if (k == 9) begin
      // area ends inside an option
      k = $urandom_range(1, 6);
      while (k > 0 && pkt.size() > 1) begin
        r = pkt.pop_back();
        k--;
      end
    end
    // occasional restart in mid-area
    if ($urandom_range(0, 9) == 0 && pkt.size() > 2) begin
      idx = $urandom_range(1, pkt.size() - 1);
      r = pkt[idx];
      r.packet_start = 1'b1;
      pkt[idx] = r;
    end
    mark_last();
  endtask

  // Garbage: random bytes, stray restarts and early end flags.
  task automatic build_broken();
    int n;
    n = $urandom_range(1, 20);
    pkt.delete();
    for (int i = 0; i < n; i++) begin
      pkt.push_back(opt_req(rand_byte(), (i == 0) || ($urandom_range(0, 9) == 0),
                            $urandom_range(0, 5) == 0));
    end
    mark_last();
  endtask

  // Bytes with no packet_start after a stopped parse; ignored by the block.
  task automatic build_noise();
    int n;
    n = $urandom_range(1, 4);
    pkt.delete();
    repeat (n) pkt.push_back(opt_req(rand_byte(), 1'b0, 1'($urandom_range(0, 1))));
  endtask

  // Full-size area of long skipped options with no end flag: the parse
  // must run out at the last byte position.
  task automatic build_area_fill();
    int len;
    pkt.delete();
    pkt.push_back(opt_req(rand_byte(), 1'b1, 1'b0));
    repeat (3) pkt.push_back(opt_req(rand_byte(), 1'b0, 1'b0));
    while (pkt.size() < AreaBytes) begin
      len = $urandom_range(200, 255);
      pkt.push_back(opt_req(8'($urandom_range(1, 254)), 1'b0, 1'b0));
      pkt.push_back(opt_req(8'(len), 1'b0, 1'b0));
      repeat (len) pkt.push_back(opt_req(rand_byte(), 1'b0, 1'b0));
    end
    while (pkt.size() > AreaBytes) void'(pkt.pop_back());
  endtask

  initial begin
    int ph;
    int kind;
    int phase_bytes;
    int phase_pkts;

    in_valid <= 1'b0;
    in_req   <= '0;
    rst_n    <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed. A stop byte before any packet is ignored.
    send_req(opt_req(dote_pkg::OptEnd, 1'b0, 1'b0));
    // Infinite lease, then a pad byte stops the parse.
    pkt.delete();
    pkt.push_back(opt_req(8'h63, 1'b1, 1'b0));
    pkt.push_back(opt_req(8'h82, 1'b0, 1'b0));
    pkt.push_back(opt_req(8'h53, 1'b0, 1'b0));
    pkt.push_back(opt_req(8'h63, 1'b0, 1'b0));
    pkt.push_back(opt_req(dote_pkg::OptLease, 1'b0, 1'b0));
    pkt.push_back(opt_req(8'd4, 1'b0, 1'b0));
    repeat (4) pkt.push_back(opt_req(8'hFF, 1'b0, 1'b0));
    pkt.push_back(opt_req(dote_pkg::OptPad, 1'b0, 1'b0));
    send_pkt();
    // Renewal capture cut short by the end of the area: old value stays.
    pkt.delete();
    pkt.push_back(opt_req(8'h00, 1'b1, 1'b0));
    repeat (3) pkt.push_back(opt_req(8'h00, 1'b0, 1'b0));
    pkt.push_back(opt_req(dote_pkg::OptRenewal, 1'b0, 1'b0));
    pkt.push_back(opt_req(8'd4, 1'b0, 1'b0));
    pkt.push_back(opt_req(8'h12, 1'b0, 1'b0));
    pkt.push_back(opt_req(8'h34, 1'b0, 1'b1));
    send_pkt();
    // Bare cookie and end marker, then a pad byte after the stop (ignored).
    pkt.delete();
    pkt.push_back(opt_req(8'hFF, 1'b1, 1'b0));
    repeat (3) pkt.push_back(opt_req(8'hFF, 1'b0, 1'b0));
    pkt.push_back(opt_req(dote_pkg::OptEnd, 1'b0, 1'b0));
    pkt.push_back(opt_req(dote_pkg::OptPad, 1'b0, 1'b0));
    send_pkt();
    drain_all();

    // Back-pressure: receiver holds off while short areas keep coming.
    long_hold <= 1'b1;
    repeat (8) begin
      pkt.delete();
      pkt.push_back(opt_req(rand_byte(), 1'b1, 1'b0));
      repeat (3) pkt.push_back(opt_req(rand_byte(), 1'b0, 1'b0));
      pkt.push_back(opt_req(dote_pkg::OptEnd, 1'b0, 1'b0));
      send_pkt();
    end
    drain_all();

    // Random phases: no idling, idle sender, stalling receiver, both.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 84;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 84;
        end
        default: begin
          src_idle_pct = 24;
          sink_stall_pct = 24;
        end
      endcase
      if (ph == 0) begin
        build_area_fill();
        send_pkt();
      end
      phase_bytes = 0;
      phase_pkts  = 0;
      while (phase_bytes < 50 || phase_pkts < 3) begin
        kind = $urandom_range(0, 19);
        if (kind < 14) build_good();
        else if (kind < 17) build_broken();
        else build_noise();
        send_pkt();
        if (kind < 17) begin
          phase_bytes += pkt.size();
          phase_pkts++;
        end
      end
      drain_all();
    end

    // Let any late result surface before the verdict.
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
